// File: hdl/flfa_pkg.sv
// Shared types and constants of the free-list fit allocator.
// No dependencies; imported by flfa_table and free_list_fit_allocator_unit.
package flfa_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_BITS     = 32;
  localparam int SIZE_BITS     = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } fit_policy_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOM  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_ALLOC  = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

endpackage

// File: hdl/free_list_fit_allocator_unit.sv
// Free-list fit allocator top level: sequencer, shared compare/arith path, result register.
// Depends on flfa_pkg and flfa_table.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+------------------------------
//  request   | cmd_i, block_start_i, amount_i          | start high, busy low at edge
//  result    | status_o, granted_address_o             | result_valid_o, one cycle
//  config    | fit_policy_i                            | fit_policy_we_i at edge
//
// An append, or an allocate on an empty table, answers in the cycle after the request
// and leaves busy low. An allocate scans the table through the single registered read
// port, one entry a cycle, then an update state answers a grant; a miss answers at the
// end of the scan. An exact fit then moves the later entries up, one a cycle through the
// same port, busy held until done. Reset empties the table at once; the receiver cannot
// stall results.
module free_list_fit_allocator_unit
  import flfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd_i,
  input  logic [ADDR_BITS-1:0] block_start_i,
  input  logic [SIZE_BITS-1:0] amount_i,
  input  logic                 fit_policy_we_i,
  input  logic [1:0]           fit_policy_i,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [ADDR_BITS-1:0] granted_address_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_SHIFT
  } state_e;

  state_e               state_q;
  fit_policy_e          policy_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     nfp_q;
  logic [SIZE_BITS-1:0] want_q;
  logic [CNT_W-1:0]     scan_k_q;
  logic [IDX_W-1:0]     iss_idx_q;
  logic                 chk_vld_q;
  logic [IDX_W-1:0]     chk_idx_q;
  logic                 sel_vld_q;
  logic [IDX_W-1:0]     sel_idx_q;
  entry_t               sel_q;
  logic [CNT_W-1:0]     sh_rd_q;
  logic                 sh_wr_vld_q;
  logic [IDX_W-1:0]     sh_wr_addr_q;
  logic                 res_vld_q;
  status_e              status_q;
  logic [ADDR_BITS-1:0] grant_q;

  tbl_wr_t              tbl_wr;
  tbl_rd_t              tbl_rd;
  entry_t               rd_data;

  logic                 accept;
  logic                 full;
  logic                 issue;
  logic                 fits;
  logic                 better;
  logic                 exact;
  logic                 sh_rd;
  logic [IDX_W-1:0]     scan_start;
  logic [IDX_W-1:0]     iss_idx_nxt;

  flfa_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_i      (tbl_rd),
    .rd_data_o (rd_data)
  );

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign full        = (cnt_q == CNT_W'(TABLE_ENTRIES));
  assign issue       = (state_q == S_SCAN) && (scan_k_q < cnt_q);
  assign sh_rd       = (state_q == S_SHIFT) && (sh_rd_q < cnt_q);
  assign fits        = (rd_data.size >= want_q);
  assign better      = (policy_q == POL_BEST) ? (rd_data.size < sel_q.size)
                                              : (rd_data.size > sel_q.size);
  assign exact       = (sel_q.size == want_q);
  assign scan_start  = ((policy_q == POL_NEXT) && ({1'b0, nfp_q} < cnt_q)) ? nfp_q : '0;
  assign iss_idx_nxt = (({1'b0, iss_idx_q} + CNT_W'(1)) == cnt_q) ? '0
                                                                  : iss_idx_q + IDX_W'(1);

  always_comb begin
    tbl_wr      = '0;
    tbl_rd      = '0;
    case (state_q)
      S_IDLE: begin
        tbl_wr.en   = accept && (cmd_i == CMD_APPEND) && !full;
        tbl_wr.addr = cnt_q[IDX_W-1:0];
        tbl_wr.data = '{start: block_start_i, size: amount_i};
      end
      S_SCAN: begin
        tbl_rd.en   = issue;
        tbl_rd.addr = iss_idx_q;
      end
      S_UPD: begin
        tbl_wr.en   = !exact;
        tbl_wr.addr = sel_idx_q;
        tbl_wr.data = '{start: sel_q.start + ADDR_BITS'(want_q),
                        size:  sel_q.size - want_q};
      end
      S_SHIFT: begin
        tbl_rd.en   = sh_rd;
        tbl_rd.addr = sh_rd_q[IDX_W-1:0];
        tbl_wr.en   = sh_wr_vld_q;
        tbl_wr.addr = sh_wr_addr_q;
        tbl_wr.data = rd_data;
      end
      default: begin
        tbl_wr = '0;
        tbl_rd = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      policy_q     <= POL_FIRST;
      cnt_q        <= '0;
      nfp_q        <= '0;
      want_q       <= '0;
      scan_k_q     <= '0;
      iss_idx_q    <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      sel_vld_q    <= 1'b0;
      sel_idx_q    <= '0;
      sel_q        <= '0;
      sh_rd_q      <= '0;
      sh_wr_vld_q  <= 1'b0;
      sh_wr_addr_q <= '0;
      res_vld_q    <= 1'b0;
      status_q     <= ST_OK;
      grant_q      <= '0;
    end else begin
      res_vld_q <= 1'b0;
      if (fit_policy_we_i) begin
        policy_q <= fit_policy_e'(fit_policy_i);
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            grant_q <= '0;
            if (cmd_i == CMD_APPEND) begin
              res_vld_q <= 1'b1;
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_OK;
                cnt_q    <= cnt_q + CNT_W'(1);
              end
            end else if (cnt_q == '0) begin
              res_vld_q <= 1'b1;
              status_q  <= ST_OOM;
            end else begin
              state_q   <= S_SCAN;
              want_q    <= amount_i;
              scan_k_q  <= '0;
              iss_idx_q <= scan_start;
              chk_vld_q <= 1'b0;
              sel_vld_q <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          chk_vld_q <= issue;
          chk_idx_q <= iss_idx_q;
          if (issue) begin
            scan_k_q  <= scan_k_q + CNT_W'(1);
            iss_idx_q <= iss_idx_nxt;
          end
          if (chk_vld_q && fits &&
              ((policy_q == POL_FIRST) || (policy_q == POL_NEXT))) begin
            sel_idx_q <= chk_idx_q;
            sel_q     <= rd_data;
            sel_vld_q <= 1'b1;
            state_q   <= S_UPD;
          end else if (chk_vld_q && fits && (!sel_vld_q || better)) begin
            sel_idx_q <= chk_idx_q;
            sel_q     <= rd_data;
            sel_vld_q <= 1'b1;
          end else if (!issue && !chk_vld_q) begin
            if (sel_vld_q) begin
              state_q <= S_UPD;
            end else begin
              res_vld_q <= 1'b1;
              status_q  <= ST_OOM;
              grant_q   <= '0;
              state_q   <= S_IDLE;
            end
          end
        end
        S_UPD: begin
          res_vld_q <= 1'b1;
          status_q  <= ST_OK;
          grant_q   <= sel_q.start;
          if (policy_q == POL_NEXT) begin
            nfp_q <= sel_idx_q;
          end
          if (exact) begin
            state_q     <= S_SHIFT;
            sh_rd_q     <= {1'b0, sel_idx_q} + CNT_W'(1);
            sh_wr_vld_q <= 1'b0;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SHIFT: begin
          sh_wr_vld_q <= sh_rd;
          if (sh_rd) begin
            sh_rd_q      <= sh_rd_q + CNT_W'(1);
            sh_wr_addr_q <= sh_rd_q[IDX_W-1:0] - IDX_W'(1);
          end else if (!sh_wr_vld_q) begin
            cnt_q   <= cnt_q - CNT_W'(1);
            nfp_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o    = res_vld_q;
  assign status_o          = status_q;
  assign granted_address_o = grant_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1) ||
         cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && status_q != ST_OK) |-> (grant_q == '0))
    else $error("address granted on a failed request");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> ({1'b0, iss_idx_q} < cnt_q))
    else $error("scan read beyond filled entries");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_ALLOC && cnt_q != '0) |=> busy)
    else $error("allocate request did not start a scan");
`endif

endmodule

// File: hdl/flfa_table.sv
// Free block table: start and size per entry, one write and one registered read port.
// Depends on flfa_pkg.
module flfa_table
  import flfa_pkg::*;
(
  input  logic    clk_i,
  input  tbl_wr_t wr_i,
  input  tbl_rd_t rd_i,
  output entry_t  rd_data_o
);

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
